// ----- src/b60id_pkg.sv -----
package b60id_pkg;

    localparam int unsigned IdLength   = 18;
    localparam int unsigned AccWidth   = 81;

    localparam logic [4:0]  POS_UNDERSCORE = 5'd0;
    localparam logic [4:0]  POS_BUCKET_HI  = 5'd1;
    localparam logic [4:0]  POS_BUCKET_MID = 5'd2;
    localparam logic [4:0]  POS_BUCKET_LO  = 5'd3;
    localparam logic [4:0]  POS_FIRST_ACC  = 5'd4;
    localparam logic [4:0]  POS_DONE       = 5'd18;

    localparam logic [5:0]  NOT_A_SYMBOL   = 6'd60;
    localparam logic [5:0]  DIGIT_LIMIT    = 6'd10;
    localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5F;

    localparam logic [15:0] BUCKET_LIMIT_RESET = 16'd36000;

    // Per-string decoding state.
    typedef struct packed {
        logic [4:0]          pos;
        logic                reject;
        logic [15:0]         bucket;
        logic [AccWidth-1:0] acc;
    } t_str_state;

    // One decoded result beat.
    typedef struct packed {
        logic        id_valid;
        logic [31:0] high_id;
        logic [63:0] low_id;
    } t_result;

    // Map a byte to its place in the 60-symbol alphabet (O and Q absent).
    function automatic logic [5:0] symbol_value(input logic [7:0] c);
        logic [5:0] v;
        v = NOT_A_SYMBOL;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 6'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 6'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h4E) begin
            v = 6'(c - 8'h41 + 8'd36);
        end else if (c == 8'h50) begin
            v = 6'd50;
        end else if (c >= 8'h52 && c <= 8'h5A) begin
            v = 6'(c - 8'h52 + 8'd51);
        end
        return v;
    endfunction

endpackage

// ----- src/b60id_if.sv -----
interface b60id_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_byte;

    modport source (output valid, output char_byte, output last_byte, input ready);
    modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface b60id_result_if;
    logic        valid;
    logic        ready;
    logic        id_valid;
    logic [31:0] high_id;
    logic [63:0] low_id;

    modport source (output valid, output id_valid, output high_id, output low_id, input ready);
    modport sink   (input valid, input id_valid, input high_id, input low_id, output ready);
endinterface

interface b60id_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] bucket_limit;

    modport source (output valid, output bucket_limit, input ready);
    modport sink   (input valid, input bucket_limit, output ready);
endinterface

// ----- src/b60id_step.sv -----
module b60id_step
    import b60id_pkg::*;
(
    input  t_str_state  i_state,
    input  logic [7:0]  i_char_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_bucket_limit,
    output t_str_state  o_state,
    output t_result     o_result
);

    logic [5:0]          sym;
    logic                is_sym;
    logic                is_digit;
    logic [5:0]          vs;
    logic [AccWidth-1:0] acc_x60;
    t_str_state          upd;
    logic                ok;

    // Classify the byte.
    assign sym      = symbol_value(i_char_byte);
    assign is_sym   = (sym != NOT_A_SYMBOL);
    assign is_digit = (sym < DIGIT_LIMIT);
    assign vs       = is_sym ? sym : 6'd0;

    // Multiply by 60 as 64x - 4x, wrapping at the accumulator width.
    assign acc_x60 = (i_state.acc << 6) - (i_state.acc << 2);

    // Advance the string state by one byte.
    always_comb begin
        upd = i_state;
        if (i_state.pos < POS_DONE) begin
            if (i_state.pos == POS_UNDERSCORE) begin
                if (i_char_byte != CHAR_UNDERSCORE) begin
                    upd.reject = 1'b1;
                end
            end else begin
                if (!is_sym) begin
                    upd.reject = 1'b1;
                end
                if ((i_state.pos == POS_BUCKET_HI || i_state.pos == POS_FIRST_ACC)
                    && !is_digit) begin
                    upd.reject = 1'b1;
                end
                case (i_state.pos)
                    POS_BUCKET_HI: begin
                        upd.bucket = is_digit ? (16'(vs) * 16'd3600) : 16'd0;
                    end
                    POS_BUCKET_MID: begin
                        upd.bucket = i_state.bucket + (16'(vs) * 16'd60);
                    end
                    POS_BUCKET_LO: begin
                        upd.bucket = i_state.bucket + 16'(vs);
                    end
                    default: begin
                        upd.acc = acc_x60 + AccWidth'(vs);
                    end
                endcase
            end
            upd.pos = i_state.pos + 5'd1;
        end
    end

    // Judge and format the result from the updated state.
    always_comb begin
        ok = !upd.reject && (upd.pos >= POS_DONE) && (upd.bucket != 16'd0)
             && (upd.bucket < i_bucket_limit);
        o_result.id_valid = ok;
        o_result.high_id  = ok ? ({upd.bucket, 16'd0} + 32'(upd.acc[AccWidth-1:64])) : 32'd0;
        o_result.low_id   = ok ? upd.acc[63:0] : 64'd0;
    end

    // Start over after the last byte.
    always_comb begin
        if (i_last_byte) begin
            o_state = '0;
        end else begin
            o_state = upd;
        end
    end

endmodule

// ----- src/b60id_out_skid.sv -----
module b60id_out_skid
    import b60id_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_result               i_result,
    output logic                  o_ready,
    b60id_result_if.source        o_id
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop     = r_out_valid && o_id.ready;
    assign o_ready = !r_skid_valid;

    // Fill the output register first; park a beat in the skid when it is held.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out        = i_result;
                n_out_valid  = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_id.valid    = r_out_valid;
    assign o_id.id_valid = r_out.id_valid;
    assign o_id.high_id  = r_out.high_id;
    assign o_id.low_id   = r_out.low_id;

endmodule

// ----- src/base60_id_string_decoder_top.sv -----
// Channel   Dir  Beat contents                     Notes
// i_char    in   char_byte[7:0], last_byte          one byte of the id string
// o_id      out  id_valid, high_id[31:0], low_id    one beat per last_byte
// i_cfg     in   bucket_limit[15:0]                 always ready
//
// One byte is taken per cycle while i_char.ready is high; the string state
// register updates in the same cycle through the base-60 shift-add and pattern check.
// A result is registered into the output register, or into the skid entry if that is held, when its last byte is taken.
// A two-entry output stage (register plus skid) lets bytes flow while a
// result waits; i_char.ready drops only when both entries are full.
// Synchronous active-low reset clears the string state and sets
// bucket_limit to 36000.
module base60_id_string_decoder_top
    import b60id_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    b60id_char_if.sink      i_char,
    b60id_cfg_if.sink       i_cfg,
    b60id_result_if.source  o_id
);

    t_str_state  r_state, n_state;
    logic [15:0] r_bucket_limit;
    t_result     result;
    logic        accept;
    logic        out_ready;

    assign i_cfg.ready  = 1'b1;
    assign i_char.ready = out_ready;
    assign accept       = i_char.valid && out_ready;

    // Hold the bucket limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_limit <= BUCKET_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_bucket_limit <= i_cfg.bucket_limit;
        end
    end

    b60id_step u_step (
        .i_state        (r_state),
        .i_char_byte    (i_char.char_byte),
        .i_last_byte    (i_char.last_byte),
        .i_bucket_limit (r_bucket_limit),
        .o_state        (n_state),
        .o_result       (result)
    );

    // Advance the string state on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    b60id_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept && i_char.last_byte),
        .i_result (result),
        .o_ready  (out_ready),
        .o_id     (o_id)
    );

endmodule

// ----- src/b60id_checker.sv -----
module b60id_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_char_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_id_valid,
    input logic [31:0] i_high_id,
    input logic [63:0] i_low_id
);

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat present after reset");

    // A held result beat keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_id_valid) && $stable(i_high_id) && $stable(i_low_id))
        else $error("held result beat changed");

    // A rejected id carries zero fields.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_id_valid |-> i_high_id == 32'd0 && i_low_id == 64'd0)
        else $error("rejected id with nonzero fields");

    // A valid id has nonzero high_id[31:16] (the bucket plus any carry from the accumulator).
    a_bucket_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_id_valid |-> i_high_id[31:16] != 16'd0)
        else $error("valid id with zero bucket");

    // Input stalls only while a result is pending.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_char_ready |-> i_out_valid)
        else $error("input stalled with no pending result");

endmodule

bind base60_id_string_decoder_top b60id_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_char_ready (i_char.ready),
    .i_out_valid  (o_id.valid),
    .i_out_ready  (o_id.ready),
    .i_id_valid   (o_id.id_valid),
    .i_high_id    (o_id.high_id),
    .i_low_id     (o_id.low_id)
);
